// ----- rtl/cpu8_pkg.sv -----
`default_nettype none
package cpu8_pkg;

  // status register bit positions
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagB = 4;
  localparam int unsigned FlagU = 5;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  localparam logic [7:0] StatusHeld = 8'hCF;
  localparam logic [7:0] SpReset    = 8'hFF;

  localparam logic [1:0] StackNone = 2'd0;
  localparam logic [1:0] StackPush = 2'd1;
  localparam logic [1:0] StackPull = 2'd2;

  typedef enum logic [5:0] {
    OP_NOP, OP_ILL, OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_SBC, OP_STA, OP_LDA,
    OP_CMP, OP_SHA, OP_SHM, OP_STX, OP_STY, OP_LDX, OP_LDY, OP_DEC, OP_INC,
    OP_CPX, OP_CPY, OP_BIT, OP_BR, OP_FLAG, OP_TAX, OP_TXA, OP_TAY, OP_TYA,
    OP_TXS, OP_TSX, OP_INX, OP_INY, OP_DEX, OP_DEY, OP_PHA, OP_PHP, OP_PLA,
    OP_PLP
  } op_e;

  // classified instruction handed from front to back
  typedef struct packed {
    op_e        op;
    logic [2:0] aux;
    logic [7:0] operand;
  } uop_t;

  // one result transaction
  typedef struct packed {
    logic       mem_write;
    logic [7:0] write_data;
    logic [1:0] stack_use;
    logic       branch_taken;
    logic       illegal_opcode;
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] status;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/cpu8_execute_unit.sv -----
`default_nettype none
// Execute stage of a 6502-style CPU, queue ports on both sides. One
// instruction per cycle while the input is not stalled: the front decodes
// the opcode as it is pushed, a two-entry queue holds decoded instructions,
// and the back updates A, X, Y, SP and P and places the result in a
// two-entry result queue. A result reaches the result ports from a register
// written when the back accepts its instruction; only a held-off pop stalls
// the input.
module cpu8_execute_unit import cpu8_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] opcode_i,
  input  wire logic [7:0] operand_i,
  output logic            empty,
  input  wire logic       pop,
  output logic            mem_write_o,
  output logic [7:0]      write_data_o,
  output logic [1:0]      stack_use_o,
  output logic            branch_taken_o,
  output logic            illegal_opcode_o,
  output logic [7:0]      acc_out_o,
  output logic [7:0]      x_out_o,
  output logic [7:0]      y_out_o,
  output logic [7:0]      sp_out_o,
  output logic [7:0]      status_out_o
);

  uop_t    dec_uop, q_uop;
  logic    q_valid, q_rd;
  result_t res;

  // decode
  cpu8_front u_front (
    .opcode_i  (opcode_i),
    .operand_i (operand_i),
    .uop_o     (dec_uop)
  );

  // decoupling queue
  cpu8_uop_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_data_i (dec_uop),
    .full_o    (full),
    .rd_i      (q_rd),
    .rd_data_o (q_uop),
    .valid_o   (q_valid)
  );

  // execute
  cpu8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uop_i       (q_uop),
    .uop_valid_i (q_valid),
    .uop_rd_o    (q_rd),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign mem_write_o      = res.mem_write;
  assign write_data_o     = res.write_data;
  assign stack_use_o      = res.stack_use;
  assign branch_taken_o   = res.branch_taken;
  assign illegal_opcode_o = res.illegal_opcode;
  assign acc_out_o        = res.acc;
  assign x_out_o          = res.x;
  assign y_out_o          = res.y;
  assign sp_out_o         = res.sp;
  assign status_out_o     = res.status;

endmodule
`default_nettype wire

// ----- rtl/cpu8_front.sv -----
`default_nettype none
module cpu8_front import cpu8_pkg::*; (
  input  wire logic [7:0] opcode_i,
  input  wire logic [7:0] operand_i,
  output uop_t            uop_o
);

  logic [1:0] cc;
  logic [2:0] aaa;
  logic [2:0] bbb;

  assign cc  = opcode_i[1:0];
  assign aaa = opcode_i[7:5];
  assign bbb = opcode_i[4:2];

  // opcode classification
  always_comb begin
    uop_o.op      = OP_ILL;
    uop_o.aux     = 3'd0;
    uop_o.operand = operand_i;
    if (cc == 2'd1) begin
      if (opcode_i == 8'h89) begin
        uop_o.op = OP_ILL;
      end else begin
        case (aaa)
          3'd0:    uop_o.op = OP_ORA;
          3'd1:    uop_o.op = OP_AND;
          3'd2:    uop_o.op = OP_EOR;
          3'd3:    uop_o.op = OP_ADC;
          3'd4:    uop_o.op = OP_STA;
          3'd5:    uop_o.op = OP_LDA;
          3'd6:    uop_o.op = OP_CMP;
          default: uop_o.op = OP_SBC;
        endcase
      end
    end else if (cc == 2'd2 && !aaa[2] && (bbb[0] || bbb == 3'd2)) begin
      uop_o.op  = (bbb == 3'd2) ? OP_SHA : OP_SHM;
      uop_o.aux = {1'b0, aaa[1:0]};
    end else begin
      case (opcode_i) inside
        8'h86, 8'h96, 8'h8E:               uop_o.op = OP_STX;
        8'h84, 8'h94, 8'h8C:               uop_o.op = OP_STY;
        8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: uop_o.op = OP_LDX;
        8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: uop_o.op = OP_LDY;
        8'hC6, 8'hD6, 8'hCE, 8'hDE:        uop_o.op = OP_DEC;
        8'hE6, 8'hF6, 8'hEE, 8'hFE:        uop_o.op = OP_INC;
        8'hC0, 8'hC4, 8'hCC:               uop_o.op = OP_CPY;
        8'hE0, 8'hE4, 8'hEC:               uop_o.op = OP_CPX;
        8'h24, 8'h2C:                      uop_o.op = OP_BIT;
        8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: begin
          uop_o.op  = OP_BR;
          uop_o.aux = opcode_i[7:5];
        end
        8'h18, 8'h38, 8'h58, 8'h78, 8'hB8, 8'hD8, 8'hF8: begin
          uop_o.op  = OP_FLAG;
          uop_o.aux = opcode_i[7:5];
        end
        8'hAA: uop_o.op = OP_TAX;
        8'h8A: uop_o.op = OP_TXA;
        8'hA8: uop_o.op = OP_TAY;
        8'h98: uop_o.op = OP_TYA;
        8'h9A: uop_o.op = OP_TXS;
        8'hBA: uop_o.op = OP_TSX;
        8'hE8: uop_o.op = OP_INX;
        8'hC8: uop_o.op = OP_INY;
        8'hCA: uop_o.op = OP_DEX;
        8'h88: uop_o.op = OP_DEY;
        8'h48: uop_o.op = OP_PHA;
        8'h08: uop_o.op = OP_PHP;
        8'h68: uop_o.op = OP_PLA;
        8'h28: uop_o.op = OP_PLP;
        8'hEA, 8'h00, 8'h20, 8'h40, 8'h60, 8'h4C, 8'h6C: uop_o.op = OP_NOP;
        default: uop_o.op = OP_ILL;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cpu8_uop_queue.sv -----
`default_nettype none
module cpu8_uop_queue import cpu8_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  uop_t      wr_data_i,
  output logic      full_o,
  input  wire logic rd_i,
  output uop_t      rd_data_o,
  output logic      valid_o
);

  uop_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign full_o    = (cnt_q == 2'd2);
  assign valid_o   = (cnt_q != 2'd0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_q <= !wr_ptr_q;
      if (do_rd) rd_ptr_q <= !rd_ptr_q;
      if (do_wr && !do_rd)      cnt_q <= cnt_q + 2'd1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cpu8_back.sv -----
`default_nettype none
module cpu8_back import cpu8_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  uop_t      uop_i,
  input  wire logic uop_valid_i,
  output logic      uop_rd_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output result_t   res_o
);

  logic [7:0] a_q, x_q, y_q, sp_q, p_q;
  logic [7:0] a_d, x_d, y_d, sp_d, p_d;
  result_t    r;
  logic [7:0] m, nz_val, alu_b, shv, shr;
  logic       nz_en;
  logic [8:0] sum;
  logic [7:0] cmp_reg;
  logic [8:0] diff;
  logic       flag_sel;

  // result queue
  result_t    rq_q [2];
  logic       rw_q, rr_q;
  logic [1:0] rcnt_q;
  logic       fire, do_pop;

  assign m        = uop_i.operand;
  assign empty_o  = (rcnt_q == 2'd0);
  assign do_pop   = pop_i && !empty_o;
  assign fire     = uop_valid_i && (rcnt_q != 2'd2 || do_pop);
  assign uop_rd_o = fire;
  assign res_o    = rq_q[rr_q];

  // shared adder, compare and shifter inputs
  assign alu_b   = (uop_i.op == OP_SBC) ? ~m : m;
  assign sum     = {1'b0, a_q} + {1'b0, alu_b} + {8'd0, p_q[FlagC]};
  assign cmp_reg = (uop_i.op == OP_CPX) ? x_q : (uop_i.op == OP_CPY) ? y_q : a_q;
  assign diff    = {1'b0, cmp_reg} - {1'b0, m};
  assign shv     = (uop_i.op == OP_SHA) ? a_q : m;

  always_comb begin
    case (uop_i.aux[1:0])
      2'd0:    shr = {shv[6:0], 1'b0};
      2'd1:    shr = {shv[6:0], p_q[FlagC]};
      2'd2:    shr = {1'b0, shv[7:1]};
      default: shr = {p_q[FlagC], shv[7:1]};
    endcase
  end

  // branch condition from opcode bits
  always_comb begin
    case (uop_i.aux[2:1])
      2'd0:    flag_sel = p_q[FlagN];
      2'd1:    flag_sel = p_q[FlagV];
      2'd2:    flag_sel = p_q[FlagC];
      default: flag_sel = p_q[FlagZ];
    endcase
  end

  // execute
  always_comb begin
    a_d = a_q; x_d = x_q; y_d = y_q; sp_d = sp_q; p_d = p_q;
    nz_en = 1'b0; nz_val = 8'd0;
    r = '0;
    case (uop_i.op)
      OP_ILL:  r.illegal_opcode = 1'b1;
      OP_ORA:  begin a_d = a_q | m; nz_en = 1'b1; nz_val = a_d; end
      OP_AND:  begin a_d = a_q & m; nz_en = 1'b1; nz_val = a_d; end
      OP_EOR:  begin a_d = a_q ^ m; nz_en = 1'b1; nz_val = a_d; end
      OP_ADC, OP_SBC: begin
        a_d = sum[7:0]; nz_en = 1'b1; nz_val = a_d;
        p_d[FlagC] = sum[8];
        p_d[FlagV] = ~(a_q[7] ^ alu_b[7]) & (a_q[7] ^ sum[7]);
      end
      OP_STA:  begin r.mem_write = 1'b1; r.write_data = a_q; end
      OP_STX:  begin r.mem_write = 1'b1; r.write_data = x_q; end
      OP_STY:  begin r.mem_write = 1'b1; r.write_data = y_q; end
      OP_LDA:  begin a_d = m; nz_en = 1'b1; nz_val = m; end
      OP_LDX:  begin x_d = m; nz_en = 1'b1; nz_val = m; end
      OP_LDY:  begin y_d = m; nz_en = 1'b1; nz_val = m; end
      OP_CMP, OP_CPX, OP_CPY: begin
        p_d[FlagC] = !diff[8]; nz_en = 1'b1; nz_val = diff[7:0];
      end
      OP_SHA: begin
        p_d[FlagC] = uop_i.aux[1] ? shv[0] : shv[7];
        a_d = shr; nz_en = 1'b1; nz_val = shr;
      end
      OP_SHM: begin
        p_d[FlagC] = uop_i.aux[1] ? shv[0] : shv[7];
        r.mem_write = 1'b1; r.write_data = shr; nz_en = 1'b1; nz_val = shr;
      end
      OP_DEC: begin
        r.mem_write = 1'b1; r.write_data = m - 8'd1; nz_en = 1'b1; nz_val = m - 8'd1;
      end
      OP_INC: begin
        r.mem_write = 1'b1; r.write_data = m + 8'd1; nz_en = 1'b1; nz_val = m + 8'd1;
      end
      OP_BIT: begin
        p_d[FlagZ] = ((a_q & m) == 8'd0);
        p_d[FlagN] = m[7];
        p_d[FlagV] = m[6];
      end
      OP_BR:  r.branch_taken = (flag_sel == uop_i.aux[0]);
      OP_FLAG: begin
        case (uop_i.aux[2:1])
          2'd0:    p_d[FlagC] = uop_i.aux[0];
          2'd1:    p_d[FlagI] = uop_i.aux[0];
          2'd2:    p_d[FlagV] = 1'b0;
          default: p_d[FlagD] = uop_i.aux[0];
        endcase
      end
      OP_TAX: begin x_d = a_q; nz_en = 1'b1; nz_val = a_q; end
      OP_TXA: begin a_d = x_q; nz_en = 1'b1; nz_val = x_q; end
      OP_TAY: begin y_d = a_q; nz_en = 1'b1; nz_val = a_q; end
      OP_TYA: begin a_d = y_q; nz_en = 1'b1; nz_val = y_q; end
      OP_TXS: sp_d = x_q;
      OP_TSX: begin x_d = sp_q; nz_en = 1'b1; nz_val = sp_q; end
      OP_INX: begin x_d = x_q + 8'd1; nz_en = 1'b1; nz_val = x_d; end
      OP_INY: begin y_d = y_q + 8'd1; nz_en = 1'b1; nz_val = y_d; end
      OP_DEX: begin x_d = x_q - 8'd1; nz_en = 1'b1; nz_val = x_d; end
      OP_DEY: begin y_d = y_q - 8'd1; nz_en = 1'b1; nz_val = y_d; end
      OP_PHA: begin
        r.mem_write = 1'b1; r.write_data = a_q; r.stack_use = StackPush;
        sp_d = sp_q - 8'd1;
      end
      OP_PHP: begin
        r.mem_write = 1'b1; r.write_data = p_q | 8'h30; r.stack_use = StackPush;
        sp_d = sp_q - 8'd1;
      end
      OP_PLA: begin
        r.stack_use = StackPull; sp_d = sp_q + 8'd1;
        a_d = m; nz_en = 1'b1; nz_val = m;
      end
      OP_PLP: begin
        r.stack_use = StackPull; sp_d = sp_q + 8'd1;
        p_d = m & StatusHeld;
      end
      default: ;
    endcase
    if (nz_en) begin
      p_d[FlagZ] = (nz_val == 8'd0);
      p_d[FlagN] = nz_val[7];
    end
    r.acc = a_d; r.x = x_d; r.y = y_d; r.sp = sp_d; r.status = p_d & StatusHeld;
  end

  // architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q  <= 8'd0;
      x_q  <= 8'd0;
      y_q  <= 8'd0;
      sp_q <= SpReset;
      p_q  <= 8'd0;
    end else if (fire) begin
      a_q  <= a_d;
      x_q  <= x_d;
      y_q  <= y_d;
      sp_q <= sp_d;
      p_q  <= p_d & StatusHeld;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (fire) rq_q[rw_q] <= r;
  end

  // result pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rw_q   <= 1'b0;
      rr_q   <= 1'b0;
      rcnt_q <= 2'd0;
    end else begin
      if (fire)   rw_q <= !rw_q;
      if (do_pop) rr_q <= !rr_q;
      if (fire && !do_pop)      rcnt_q <= rcnt_q + 2'd1;
      else if (do_pop && !fire) rcnt_q <= rcnt_q - 2'd1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cpu8_checker.sv -----
`default_nettype none
module cpu8_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic       mem_write_i,
  input wire logic [7:0] write_data_i,
  input wire logic [1:0] stack_use_i,
  input wire logic       illegal_opcode_i,
  input wire logic [7:0] status_out_i
);

  // waiting transaction stays and its write data holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(write_data_i))
    else $error("stalled result changed");

  // illegal opcode touches no memory or stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && illegal_opcode_i |-> !mem_write_i && stack_use_i == 2'd0)
    else $error("illegal opcode with side effect");

  // unheld status bits read zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> status_out_i[5:4] == 2'b00)
    else $error("status bits four or five set");

  // no write data without a write, push implies write, stack code 3 unused
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (mem_write_i || write_data_i == 8'd0) &&
               (stack_use_i != 2'd1 || mem_write_i) && stack_use_i != 2'd3)
    else $error("write data or stack code inconsistent");

endmodule

bind cpu8_execute_unit cpu8_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .empty            (empty),
  .pop              (pop),
  .mem_write_i      (mem_write_o),
  .write_data_i     (write_data_o),
  .stack_use_i      (stack_use_o),
  .illegal_opcode_i (illegal_opcode_o),
  .status_out_i     (status_out_o)
);
`default_nettype wire
